FILE: sv/bitmap_id_allocator_assert.svh
// Assertion macros for the allocator's top-level RTL file.
`ifndef BITMAP_ID_ALLOCATOR_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BIA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bia_pkg.sv
`default_nettype none

package bia_pkg;

  // Default id count and fixed field geometry.
  localparam int unsigned NUM_IDS_DEF = 1024;
  localparam int unsigned WORD_BITS   = 8;
  localparam int unsigned BIT_IDX_W   = 3;
  localparam int unsigned SLOT_ID_W   = 10;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [WORD_BITS-1:0] FULL_WORD = 8'hFF;
  localparam logic [WORD_BITS-1:0] ONE_BIT   = 8'h01;

  // Request operation codes.
  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } bia_op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NONE_FREE = 2'd1,
    STAT_RANGE     = 2'd2
  } bia_status_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } bia_state_t;

  typedef struct packed {
    bia_op_t              op;
    logic [SLOT_ID_W-1:0] slot_id;
  } bia_req_t;

  typedef struct packed {
    logic [SLOT_ID_W-1:0] granted_id;
    bia_status_t          status;
  } bia_rsp_t;

  // Index of the lowest clear bit of a word; only meaningful when the word is not full.
  function automatic logic [BIT_IDX_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: sv/bitmap_id_allocator.sv
`default_nettype none

// Bitmap id allocator. A request (op, slot_id) is taken when start is high and busy
// is low. Allocate scans bitmap words from the hint word upward, one memory read per
// cycle, and grants the lowest free id of the first word with room; it never wraps,
// so it reports none free once the last word is passed. Release clears the id's bit
// and moves the hint to its word; an out-of-range release is answered without a
// memory access. The result appears on out_rsp with out_valid high for exactly one
// cycle, starting the cycle after the work ends; it cannot be stalled and must be
// captured then. busy is already low during that cycle, so the next request can be
// taken there. After reset the bitmap memory is cleared one word per cycle, all
// NUM_WORDS words (128 at the default size), with busy held high.

module bitmap_id_allocator
  import bia_pkg::*;
#(
  parameter int unsigned NUM_IDS = NUM_IDS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire bia_req_t in_req,
  output logic          out_valid,
  output bia_rsp_t      out_rsp
);

  localparam int unsigned NUM_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned TAIL_BITS = NUM_IDS % WORD_BITS;
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);
  // Bits past the last valid id in a partial last word read as used.
  localparam logic [WORD_BITS-1:0] PAD_MASK =
    (TAIL_BITS == 0) ? '0 : WORD_BITS'(FULL_WORD << TAIL_BITS);

  bia_state_t               state_r, state_nxt;
  logic [WORD_AW-1:0]       hint_r, hint_nxt;
  logic [WORD_AW-1:0]       word_r, word_nxt;
  logic [WORD_AW-1:0]       clr_r, clr_nxt;
  bia_op_t                  op_r, op_nxt;
  logic [BIT_IDX_W-1:0]     bit_r, bit_nxt;
  logic [SLOT_ID_W-1:0]     id_r, id_nxt;
  logic                     out_valid_r, out_valid_nxt;
  bia_rsp_t                 out_rsp_r, out_rsp_nxt;

  logic                     mem_wr_en, mem_rd_en;
  logic [WORD_AW-1:0]       mem_wr_addr, mem_rd_addr;
  logic [WORD_BITS-1:0]     mem_wr_data, mem_rd_data;

  logic                     accept;
  logic                     in_range;
  logic [WORD_AW-1:0]       in_word;
  logic [WORD_BITS-1:0]     eff_word;
  logic                     word_full;
  logic [BIT_IDX_W-1:0]     free_bit;

  bia_bitmap_ram #(
    .DEPTH (NUM_WORDS),
    .AW    (WORD_AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Request decode.
  assign accept   = start && (state_r == ST_IDLE);
  assign in_range = 32'(in_req.slot_id) < 32'(NUM_IDS);
  assign in_word  = WORD_AW'(in_req.slot_id >> BIT_IDX_W);

  // Word as the scan sees it, with padding bits of the last word forced used.
  assign eff_word  = mem_rd_data | ((word_r == LAST_WORD) ? PAD_MASK : '0);
  assign word_full = (eff_word == FULL_WORD);
  assign free_bit  = lowest_zero(eff_word);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && !(in_req.op == OP_RELEASE && !in_range)) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (op_r == OP_RELEASE || !word_full || word_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory control, bookkeeping and result formation.
  always_comb begin
    hint_nxt      = hint_r;
    word_nxt      = word_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    bit_nxt       = bit_r;
    id_nxt        = id_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = word_r;
    mem_wr_data   = mem_rd_data;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = word_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_r;
        mem_wr_data = '0;
        clr_nxt     = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt  = in_req.op;
          bit_nxt = in_req.slot_id[BIT_IDX_W-1:0];
          id_nxt  = in_req.slot_id;
          if (in_req.op == OP_ALLOC) begin
            // Start the scan at the hint word.
            mem_rd_en   = 1'b1;
            mem_rd_addr = hint_r;
            word_nxt    = hint_r;
          end else if (in_range) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = in_word;
            word_nxt    = in_word;
          end else begin
            // Out-of-range release is answered at once.
            out_valid_nxt          = 1'b1;
            out_rsp_nxt.granted_id = '0;
            out_rsp_nxt.status     = STAT_RANGE;
          end
        end
      end
      ST_EVAL: begin
        if (op_r == OP_RELEASE) begin
          mem_wr_en              = 1'b1;
          mem_wr_data            = mem_rd_data & ~(ONE_BIT << bit_r);
          hint_nxt               = word_r;
          out_valid_nxt          = 1'b1;
          out_rsp_nxt.granted_id = id_r;
          out_rsp_nxt.status     = STAT_OK;
        end else if (!word_full) begin
          // Claim the lowest free bit of this word.
          mem_wr_en              = 1'b1;
          mem_wr_data            = mem_rd_data | (ONE_BIT << free_bit);
          hint_nxt               = word_r;
          out_valid_nxt          = 1'b1;
          out_rsp_nxt.granted_id = SLOT_ID_W'({word_r, free_bit});
          out_rsp_nxt.status     = STAT_OK;
        end else if (word_r == LAST_WORD) begin
          out_valid_nxt          = 1'b1;
          out_rsp_nxt.granted_id = '0;
          out_rsp_nxt.status     = STAT_NONE_FREE;
        end else begin
          // Word is full: fetch the next one.
          mem_rd_en   = 1'b1;
          mem_rd_addr = word_r + 1'b1;
          word_nxt    = word_r + 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      hint_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    op_r      <= op_nxt;
    bit_r     <= bit_nxt;
    id_r      <= id_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`include "bitmap_id_allocator_assert.svh"

  // A write and a read never touch the same word in one cycle.
  `BIA_ASSERT_SAME(a_no_rw_collision, clk, rst_n, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "bitmap read and write hit the same word")
  // A taken request either keeps the block busy or is answered in the next cycle.
  `BIA_ASSERT_NEXT(a_accept_progress, clk, rst_n, accept, busy || out_valid, "accepted request made no progress")
  // Failed requests report a zero id.
  `BIA_ASSERT_SAME(a_fail_zero_id, clk, rst_n, out_valid && out_rsp.status != STAT_OK, out_rsp.granted_id == '0, "failed request returned a nonzero id")

endmodule

`default_nettype wire

FILE: sv/bia_bitmap_ram.sv
`default_nettype none

module bia_bitmap_ram
  import bia_pkg::*;
#(
  parameter int unsigned DEPTH = (NUM_IDS_DEF + WORD_BITS - 1) / WORD_BITS,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [WORD_BITS-1:0] wr_data,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bia_pkg::*;

  localparam int unsigned NUM_IDS        = NUM_IDS_DEF;
  localparam int unsigned NUM_WORDS      = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 200;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  bia_req_t in_req;
  logic     out_valid;
  bia_rsp_t out_rsp;

  // Shadow copy of the allocator state, advanced once per accepted request.
  logic [WORD_BITS-1:0] used_map [NUM_WORDS];
  int unsigned          hint_word;

  // Grants predicted for requests already taken, oldest first.
  bia_rsp_t    pending_grants [$];
  int unsigned mismatch_count;
  int unsigned stall_cycles;

  // Sender pacing: bursts of random length separated by random gaps.
  bit          paced;
  int unsigned burst_left;

  bitmap_id_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Computes the grant for one request and updates the shadow bitmap and hint.
  function automatic bia_rsp_t predict_grant(input bia_req_t req);
    bia_rsp_t             rsp;
    logic [WORD_BITS-1:0] word;
    int unsigned          w;
    int unsigned          b;
    int unsigned          valid_bits;
    bit                   found;
    rsp.granted_id = '0;
    rsp.status     = STAT_NONE_FREE;
    found          = 1'b0;
    if (req.op == OP_ALLOC) begin
      // Next-fit scan from the hint word up to the last word, no wrap.
      for (w = hint_word; w < NUM_WORDS && !found; w++) begin
        word       = used_map[w];
        valid_bits = NUM_IDS - w * WORD_BITS;
        if (valid_bits < WORD_BITS) begin
          word = word | (FULL_WORD << valid_bits);
        end
        if (word != FULL_WORD) begin
          b = 0;
          while (b < WORD_BITS && word[b]) begin
            b++;
          end
          used_map[w][b] = 1'b1;
          hint_word      = w;
          rsp.granted_id = SLOT_ID_W'(w * WORD_BITS + b);
          rsp.status     = STAT_OK;
          found          = 1'b1;
        end
      end
    end else if (req.slot_id >= NUM_IDS) begin
      rsp.status = STAT_RANGE;
    end else begin
      used_map[req.slot_id / WORD_BITS][req.slot_id % WORD_BITS] = 1'b0;
      hint_word      = req.slot_id / WORD_BITS;
      rsp.granted_id = req.slot_id;
      rsp.status     = STAT_OK;
    end
    return rsp;
  endfunction

  // Finds an id that is currently held, starting from a random point.
  function automatic bit pick_held_id(output logic [SLOT_ID_W-1:0] id);
    logic [SLOT_ID_W-1:0] probe;
    probe = SLOT_ID_W'($urandom_range(0, NUM_IDS - 1));
    for (int k = 0; k < NUM_IDS; k++) begin
      if (used_map[probe / WORD_BITS][probe % WORD_BITS]) begin
        id = probe;
        return 1'b1;
      end
      probe = SLOT_ID_W'((probe + 1) % NUM_IDS);
    end
    id = '0;
    return 1'b0;
  endfunction

  // Holds start low for the given number of cycles.
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Sends one request, waits until it is taken and records its expected grant.
  task automatic send_request(input bia_op_t op, input logic [SLOT_ID_W-1:0] id);
    bia_req_t req;
    req.op      = op;
    req.slot_id = id;
    @(negedge clk);
    start  = 1'b1;
    in_req = req;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    pending_grants.push_back(predict_grant(req));
    if (paced) begin
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, 8));
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Lets every outstanding grant arrive, then watches for stray results.
  task automatic drain_grants();
    idle_cycles(1);
    while (pending_grants.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Fills the top word after moving the hint there, then runs past the end.
  task automatic test_top_word_exhaustion();
    send_request(OP_ALLOC, '0);
    send_request(OP_RELEASE, 10'h3FF);
    repeat (WORD_BITS) send_request(OP_ALLOC, 10'h3FF);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, 10'h155);
  endtask

  // Releases of free and held ids, and allocations that follow the moved hint.
  task automatic test_release_cases();
    send_request(OP_RELEASE, '0);
    send_request(OP_RELEASE, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_RELEASE, 10'd512);
    send_request(OP_ALLOC, '0);
    send_request(OP_RELEASE, 10'd1);
    send_request(OP_ALLOC, '0);
    send_request(OP_RELEASE, 10'h2AA);
    send_request(OP_RELEASE, 10'h155);
  endtask

  // Random traffic: allocations at alloc_pct percent, otherwise mostly releases of held ids, some noise.
  task automatic test_random_traffic(input int unsigned n, input int unsigned alloc_pct,
                                     input bit pace_on);
    logic [SLOT_ID_W-1:0] id;
    int unsigned          roll;
    paced = pace_on;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        send_request(OP_ALLOC, SLOT_ID_W'($urandom_range(0, NUM_IDS - 1)));
      end else if ($urandom_range(0, 9) == 0 || !pick_held_id(id)) begin
        send_request(OP_RELEASE, SLOT_ID_W'($urandom_range(0, NUM_IDS - 1)));
      end else begin
        send_request(OP_RELEASE, id);
      end
    end
    paced = 1'b1;
  endtask

  // Compares each grant with the oldest prediction.
  always @(posedge clk) begin
    bia_rsp_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected grant: granted_id %0d status %0d",
               out_rsp.granted_id, out_rsp.status);
        mismatch_count++;
      end else begin
        want = pending_grants.pop_front();
        if (out_rsp.granted_id !== want.granted_id) begin
          $error("granted_id mismatch: expected %0d, actual %0d",
                 want.granted_id, out_rsp.granted_id);
          mismatch_count++;
        end
        if (out_rsp.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_rsp.status);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run when nothing has been taken or returned for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_req         = '0;
    hint_word      = 0;
    mismatch_count = 0;
    paced          = 1'b1;
    burst_left     = 4;
    for (int w = 0; w < NUM_WORDS; w++) begin
      used_map[w] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_top_word_exhaustion();
    test_release_cases();
    test_random_traffic(800, 90, 1'b1);
    test_random_traffic(500, 60, 1'b1);
    test_random_traffic(500, 25, 1'b1);
    test_random_traffic(200, 70, 1'b0);
    drain_grants();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
